// ===== rtl/iri_pkg.sv =====
// Shared types, constants and codes of the rotated-frame pixel engine.
// Depends on nothing; every other file of the block but iri_ram uses it.
package iri_pkg;

  localparam int MAX_DIM_DEF = 512;
  localparam int PIXEL_BITS  = 8;
  localparam logic [PIXEL_BITS-1:0] BACKGROUND = 8'd255;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int POS_W      = 9;
  localparam int DIM_CFG_W  = 10;
  localparam int COEF_W     = 16;
  localparam int COORD_W    = 14;   // signed integer part of a source position
  localparam int FRAC_W     = 8;    // fraction bits of a source position
  localparam int A_W        = 26;   // MAC weight operand, signed
  localparam int B_W        = 21;   // MAC data operand, signed
  localparam int R_W        = 20;   // row spline result, signed
  localparam int ACC_W      = 48;   // MAC accumulator, signed

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_COS_COEF     = 3'd2,
    CFG_SIN_COEF     = 3'd3,
    CFG_CENTRE_X     = 3'd4,
    CFG_CENTRE_Y     = 3'd5,
    CFG_INTERP_MODE  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_NEAREST    = 2'd0,
    MODE_BILINEAR   = 2'd1,
    MODE_BICUBIC    = 2'd2,
    MODE_BACKGROUND = 2'd3
  } interp_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ROT, S_COORD, S_WGT1, S_WGT2, S_WGT3,
    S_FETCH, S_DRAIN, S_ROW, S_COL, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_WRITE, OP_LOAD, OP_ROT, OP_COORD, OP_WGT1, OP_WGT2, OP_WGT3,
    OP_FETCH, OP_ROW, OP_COL, OP_FINAL
  } op_e;

  // controller -> datapath
  typedef struct packed {
    op_e        op;
    logic [3:0] idx;    // step, read or term number
    logic       last;   // last term of a spline pass
  } iri_cmd_t;

  // datapath -> controller
  typedef struct packed {
    interp_e mode;
    logic    inb;       // every sampled pixel lies inside the frame
    logic    out_free;  // result register can take a new value
  } iri_sts_t;

endpackage

// ===== rtl/iri_if.sv =====
// Request and result channel interfaces of the rotated-frame pixel engine.
// Depends on iri_pkg for field widths.
interface iri_req_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [iri_pkg::POS_W-1:0]        pos_x;
  logic [iri_pkg::POS_W-1:0]        pos_y;
  logic [iri_pkg::PIXEL_BITS-1:0]   pixel_in;

  modport source (output valid, action, pos_x, pos_y, pixel_in, input ready);
  modport sink   (input valid, action, pos_x, pos_y, pixel_in, output ready);
endinterface

interface iri_res_if;
  logic                             valid;
  logic                             ready;
  logic [iri_pkg::PIXEL_BITS-1:0]   pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink   (input valid, pixel_out, output ready);
endinterface

// ===== rtl/image_rotate_interpolate.sv =====
// Rotated-frame pixel engine, top level: request/result channels and
// settings write port. Depends on iri_pkg, iri_if, iri_ctrl, iri_datapath.
//
// Usage: a request with action 0 writes pixel_in into the frame at
// (pos_x, pos_y) and gives no result. A request with action 1 asks for
// destination pixel (pos_x, pos_y) of the frame rotated about (centre_x,
// centre_y) and gives one pixel_out, 255 when the sampled window leaves
// the frame or the mode is background. Timing per lookup is set by the
// one frame memory read port and the one shared multiply-accumulate unit:
// a bicubic lookup makes 16 window reads, 16 row terms and 4 column terms,
// while out-of-frame and background answers skip the reads and terms.
// A new request is taken only once the previous one has loaded its result
// register, so the next request overlaps the wait of an unread result.
// If the receiver stalls, the result holds and the engine waits in its
// final step. Reset clears the settings to their defaults and the control;
// the frame contents are undefined until written. The user must write
// settings only while the engine is idle; the block does not enforce it.
module image_rotate_interpolate #(
  parameter int MAX_DIM = iri_pkg::MAX_DIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  iri_req_if.sink                        req_i,
  iri_res_if.source                      res_o,
  input  logic                           cfg_we_i,
  input  logic [iri_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [iri_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import iri_pkg::*;

  iri_cmd_t cmd;
  iri_sts_t sts;

  iri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_action_i (req_i.action),
    .in_ready_o  (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  iri_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pos_x_i     (req_i.pos_x),
    .pos_y_i     (req_i.pos_y),
    .pixel_in_i  (req_i.pixel_in),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .pixel_out_o (res_o.pixel_out)
  );

endmodule

// ===== rtl/iri_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module iri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/iri_ctrl.sv =====
// Sequencer of the rotated-frame pixel engine: walks one request through
// rotation, weights, window fetch and spline passes. Depends on iri_pkg.
module iri_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_action_i,
  output logic              in_ready_o,
  input  iri_pkg::iri_sts_t sts_i,
  output iri_pkg::iri_cmd_t cmd_o
);
  import iri_pkg::*;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] row_q, row_d;
  logic [3:0] last_read;
  logic [1:0] last_term;

  // per-mode window size
  always_comb begin
    unique case (sts_i.mode)
      MODE_NEAREST:  begin last_read = 4'd0;  last_term = 2'd1; end
      MODE_BILINEAR: begin last_read = 4'd3;  last_term = 2'd1; end
      default:       begin last_read = 4'd15; last_term = 2'd3; end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    row_d   = row_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_action_i) begin
          state_d = S_ROT;
          cnt_d   = '0;
        end
      end
      S_ROT: begin
        if (cnt_q == 4'd3) state_d = S_COORD;
        else cnt_d = cnt_q + 4'd1;
      end
      S_COORD: state_d = S_WGT1;
      S_WGT1: begin
        if (!sts_i.inb || sts_i.mode == MODE_BACKGROUND) begin
          state_d = S_DONE;
        end else if (sts_i.mode == MODE_NEAREST) begin
          state_d = S_FETCH;
          cnt_d   = '0;
        end else begin
          state_d = S_WGT2;
        end
      end
      S_WGT2: state_d = S_WGT3;
      S_WGT3: begin
        state_d = S_FETCH;
        cnt_d   = '0;
      end
      S_FETCH: begin
        if (cnt_q == last_read) state_d = S_DRAIN;
        else cnt_d = cnt_q + 4'd1;
      end
      S_DRAIN: begin
        if (sts_i.mode == MODE_NEAREST) begin
          state_d = S_DONE;
        end else begin
          state_d = S_ROW;
          cnt_d   = '0;
          row_d   = '0;
        end
      end
      S_ROW: begin
        if (cnt_q[1:0] == last_term) begin
          cnt_d = '0;
          if (row_q == last_term) state_d = S_COL;
          else row_d = row_q + 2'd1;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_COL: begin
        if (cnt_q[1:0] == last_term) state_d = S_DONE;
        else cnt_d = cnt_q + 4'd1;
      end
      S_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.idx  = cnt_q;
    cmd_o.last = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = in_action_i ? OP_LOAD : OP_WRITE;
      end
      S_ROT:   cmd_o.op = OP_ROT;
      S_COORD: cmd_o.op = OP_COORD;
      S_WGT1:  cmd_o.op = OP_WGT1;
      S_WGT2:  cmd_o.op = OP_WGT2;
      S_WGT3:  cmd_o.op = OP_WGT3;
      S_FETCH: cmd_o.op = OP_FETCH;
      S_DRAIN: cmd_o.op = OP_NONE;
      S_ROW: begin
        cmd_o.op   = OP_ROW;
        cmd_o.last = (cnt_q[1:0] == last_term);
      end
      S_COL: begin
        cmd_o.op   = OP_COL;
        cmd_o.last = (cnt_q[1:0] == last_term);
      end
      S_DONE: begin
        if (sts_i.out_free) cmd_o.op = OP_FINAL;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  // reads never run past the window of the current mode
  a_fetch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |-> cnt_q <= last_read)
    else $error("fetch index beyond window");

  // a result load always returns the sequencer to idle
  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_FINAL |=> state_q == S_IDLE)
    else $error("sequencer not idle after result load");

  // a request starts the rotation at its first step
  a_load_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_LOAD |=> (state_q == S_ROT && cnt_q == 4'd0))
    else $error("request did not start rotation");

  // spline passes run only for interpolating modes
  a_row_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROW |-> (sts_i.mode == MODE_BILINEAR || sts_i.mode == MODE_BICUBIC))
    else $error("spline pass in non-interpolating mode");

endmodule

// ===== rtl/iri_datapath.sv =====
// Datapath of the rotated-frame pixel engine: settings, frame memory,
// shared multiply-accumulate unit, window and result register.
// Depends on iri_pkg and iri_ram.
module iri_datapath #(
  parameter int MAX_DIM = iri_pkg::MAX_DIM_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [iri_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [iri_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [iri_pkg::POS_W-1:0]          pos_x_i,
  input  logic [iri_pkg::POS_W-1:0]          pos_y_i,
  input  logic [iri_pkg::PIXEL_BITS-1:0]     pixel_in_i,
  input  iri_pkg::iri_cmd_t                  cmd_i,
  output iri_pkg::iri_sts_t                  sts_o,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output logic [iri_pkg::PIXEL_BITS-1:0]     pixel_out_o
);
  import iri_pkg::*;

  localparam int CW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = COORD_W + FRAC_W;
  localparam logic [AW-1:0] DIM_A = AW'(MAX_DIM);
  localparam logic signed [COORD_W-1:0] DIM_C = COORD_W'(MAX_DIM);

  // Hermite or linear weights, 24 fraction bits for the cubic
  function automatic logic [4*A_W-1:0] calc_weights(input logic [FRAC_W-1:0] f,
                                                     input logic [2*FRAC_W-1:0] f2,
                                                     input logic [3*FRAC_W-1:0] f3,
                                                     input logic cubic);
    logic signed [A_W+1:0] e1, e2, e3, w0, w1, w2, w3;
    e1 = $signed({{(A_W+2-FRAC_W){1'b0}}, f});
    e2 = $signed({{(A_W+2-2*FRAC_W){1'b0}}, f2});
    e3 = $signed({{(A_W+2-3*FRAC_W){1'b0}}, f3});
    if (cubic) begin
      w0 = (e3 <<< 1) - (e2 <<< 9) - (e2 <<< 8) + (28'sd1 <<< 24);
      w1 = (e2 <<< 9) + (e2 <<< 8) - (e3 <<< 1);
      w2 = e3 - (e2 <<< 9) + (e1 <<< 16);
      w3 = e3 - (e2 <<< 8);
    end else begin
      w0 = 28'sd256 - e1;
      w1 = e1;
      w2 = '0;
      w3 = '0;
    end
    return {w3[A_W-1:0], w2[A_W-1:0], w1[A_W-1:0], w0[A_W-1:0]};
  endfunction

  // window slot {row, col} of read number k
  function automatic logic [3:0] slot_of(input logic [3:0] k, input interp_e m);
    logic [3:0] s;
    unique case (m)
      MODE_BILINEAR: s = {1'b0, k[1], 1'b0, k[0]};
      MODE_BICUBIC:  s = k;
      default:       s = 4'd0;
    endcase
    return s;
  endfunction

  // settings
  logic [DIM_CFG_W-1:0]     fw_q, fh_q;
  logic signed [COEF_W-1:0] cos_q, sin_q;
  logic [POS_W-1:0]         cx_q, cy_q;
  interp_e                  mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= DIM_CFG_W'(512);
      fh_q   <= DIM_CFG_W'(512);
      cos_q  <= 16'sd16384;
      sin_q  <= '0;
      cx_q   <= '0;
      cy_q   <= '0;
      mode_q <= MODE_NEAREST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q   <= cfg_data_i[DIM_CFG_W-1:0];
        CFG_FRAME_HEIGHT: fh_q   <= cfg_data_i[DIM_CFG_W-1:0];
        CFG_COS_COEF:     cos_q  <= $signed(cfg_data_i);
        CFG_SIN_COEF:     sin_q  <= $signed(cfg_data_i);
        CFG_CENTRE_X:     cx_q   <= cfg_data_i[POS_W-1:0];
        CFG_CENTRE_Y:     cy_q   <= cfg_data_i[POS_W-1:0];
        CFG_INTERP_MODE:  mode_q <= interp_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  logic cubic;
  assign cubic = (mode_q == MODE_BICUBIC);

  // request offsets from the centre
  logic signed [POS_W:0] dx_q, dy_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      dx_q <= $signed({1'b0, pos_x_i}) - $signed({1'b0, cx_q});
      dy_q <= $signed({1'b0, pos_y_i}) - $signed({1'b0, cy_q});
    end
  end

  // window, row results and weights
  logic [PIXEL_BITS-1:0]  pw_q [4][4];
  logic signed [R_W-1:0]  r_q  [4];
  logic signed [A_W-1:0]  wx_q [4];
  logic signed [A_W-1:0]  wy_q [4];
  logic [FRAC_W-1:0]      fx_q, fy_q;
  logic [2*FRAC_W-1:0]    f2x_q, f2y_q;
  logic [3*FRAC_W-1:0]    f3x_q, f3y_q;
  logic signed [B_W-1:0]  row_t [4];
  logic signed [B_W-1:0]  col_t [4];
  logic signed [B_W-1:0]  q0, q1, q2, q3, r0, r1, r2, r3;

  assign q0 = B_W'($signed({1'b0, pw_q[0][0]}));
  assign q1 = B_W'($signed({1'b0, pw_q[0][1]}));
  assign q2 = B_W'($signed({1'b0, pw_q[0][2]}));
  assign q3 = B_W'($signed({1'b0, pw_q[0][3]}));
  assign r0 = B_W'(r_q[0]);
  assign r1 = B_W'(r_q[1]);
  assign r2 = B_W'(r_q[2]);
  assign r3 = B_W'(r_q[3]);

  // spline data terms; linear uses the first two
  always_comb begin
    if (cubic) begin
      row_t[0] = q1;  row_t[1] = q2;  row_t[2] = q1 - q0;  row_t[3] = q3 - q2;
      col_t[0] = r1;  col_t[1] = r2;  col_t[2] = r1 - r0;  col_t[3] = r3 - r2;
    end else begin
      row_t[0] = q0;  row_t[1] = q1;  row_t[2] = '0;  row_t[3] = '0;
      col_t[0] = r2;  col_t[1] = r3;  col_t[2] = '0;  col_t[3] = '0;
    end
  end

  // shared multiply-accumulate
  logic signed [A_W-1:0]     mac_a;
  logic signed [B_W-1:0]     mac_b;
  logic                      mac_en, mac_clr, mac_sub;
  logic signed [A_W+B_W-1:0] prod;
  logic signed [ACC_W-1:0]   prod_x, acc_q, acc_d;

  always_comb begin
    mac_a   = '0;
    mac_b   = '0;
    mac_en  = 1'b0;
    mac_clr = 1'b0;
    mac_sub = 1'b0;
    case (cmd_i.op)
      OP_ROT: begin
        mac_en = 1'b1;
        unique case (cmd_i.idx[1:0])
          2'd0: begin mac_a = A_W'(cos_q); mac_b = B_W'(dx_q); mac_clr = 1'b1; end
          2'd1: begin mac_a = A_W'(sin_q); mac_b = B_W'(dy_q); end
          2'd2: begin mac_a = A_W'(cos_q); mac_b = B_W'(dy_q); mac_clr = 1'b1; end
          default: begin mac_a = A_W'(sin_q); mac_b = B_W'(dx_q); mac_sub = 1'b1; end
        endcase
      end
      OP_ROW: begin
        mac_en  = 1'b1;
        mac_clr = (cmd_i.idx[1:0] == 2'd0);
        mac_a   = wx_q[cmd_i.idx[1:0]];
        mac_b   = row_t[cmd_i.idx[1:0]];
      end
      OP_COL: begin
        mac_en  = 1'b1;
        mac_clr = (cmd_i.idx[1:0] == 2'd0);
        mac_a   = wy_q[cmd_i.idx[1:0]];
        mac_b   = col_t[cmd_i.idx[1:0]];
      end
      default: ;
    endcase
  end

  assign prod   = mac_a * mac_b;
  assign prod_x = {{(ACC_W-A_W-B_W){prod[A_W+B_W-1]}}, prod};
  assign acc_d  = (mac_clr ? '0 : acc_q) + (mac_sub ? -prod_x : prod_x);

  logic signed [A_W-1:0] xr_q, yr_q;
  always_ff @(posedge clk_i) begin
    if (mac_en) acc_q <= acc_d;
    if (cmd_i.op == OP_ROT && cmd_i.idx[1:0] == 2'd1) xr_q <= acc_d[A_W-1:0];
    if (cmd_i.op == OP_ROT && cmd_i.idx[1:0] == 2'd3) yr_q <= acc_d[A_W-1:0];
  end

  // source position, window origin and bounds
  logic signed [A_W-1:0]     xs, ys;
  logic signed [XW-1:0]      xpos, ypos;
  logic signed [COORD_W-1:0] lo_x, lo_y, hi_x, hi_y, wlim, hlim, off, span;
  logic signed [COORD_W-1:0] fw_s, fh_s;
  logic                      inb_c, inb_q;
  logic [CW-1:0]             lo_x_q, lo_y_q;

  always_comb begin
    xs   = xr_q >>> 6;
    ys   = yr_q >>> 6;
    xpos = XW'(xs) + $signed({{(XW-POS_W-FRAC_W){1'b0}}, cx_q, {FRAC_W{1'b0}}});
    ypos = XW'(ys) + $signed({{(XW-POS_W-FRAC_W){1'b0}}, cy_q, {FRAC_W{1'b0}}});
    unique case (mode_q)
      MODE_BILINEAR: begin off = '0;               span = COORD_W'(1); end
      MODE_BICUBIC:  begin off = COORD_W'(1);      span = COORD_W'(3); end
      default:       begin off = '0;               span = '0;          end
    endcase
    lo_x  = $signed(xpos[XW-1:FRAC_W]) - off;
    lo_y  = $signed(ypos[XW-1:FRAC_W]) - off;
    hi_x  = lo_x + span;
    hi_y  = lo_y + span;
    fw_s  = $signed({{(COORD_W-DIM_CFG_W){1'b0}}, fw_q});
    fh_s  = $signed({{(COORD_W-DIM_CFG_W){1'b0}}, fh_q});
    wlim  = (fw_s > DIM_C) ? DIM_C : fw_s;
    hlim  = (fh_s > DIM_C) ? DIM_C : fh_s;
    inb_c = !lo_x[COORD_W-1] && !lo_y[COORD_W-1] && (hi_x < wlim) && (hi_y < hlim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inb_q <= 1'b0;
    end else if (cmd_i.op == OP_COORD) begin
      inb_q <= inb_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_COORD) begin
      lo_x_q <= lo_x[CW-1:0];
      lo_y_q <= lo_y[CW-1:0];
      fx_q   <= xpos[FRAC_W-1:0];
      fy_q   <= ypos[FRAC_W-1:0];
    end
  end

  // weight powers and weights
  logic [4*A_W-1:0] wxp, wyp;
  assign wxp = calc_weights(fx_q, f2x_q, f3x_q, cubic);
  assign wyp = calc_weights(fy_q, f2y_q, f3y_q, cubic);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WGT1) begin
      f2x_q <= {{FRAC_W{1'b0}}, fx_q} * {{FRAC_W{1'b0}}, fx_q};
      f2y_q <= {{FRAC_W{1'b0}}, fy_q} * {{FRAC_W{1'b0}}, fy_q};
    end
    if (cmd_i.op == OP_WGT2) begin
      f3x_q <= {{FRAC_W{1'b0}}, f2x_q} * {{(2*FRAC_W){1'b0}}, fx_q};
      f3y_q <= {{FRAC_W{1'b0}}, f2y_q} * {{(2*FRAC_W){1'b0}}, fy_q};
    end
    if (cmd_i.op == OP_WGT3) begin
      for (int k = 0; k < 4; k++) begin
        wx_q[k] <= $signed(wxp[k*A_W +: A_W]);
        wy_q[k] <= $signed(wyp[k*A_W +: A_W]);
      end
    end
  end

  // frame memory
  logic                  ram_we;
  logic [AW-1:0]         waddr, raddr;
  logic [PIXEL_BITS-1:0] ram_rdata;
  logic [3:0]            rd_slot, cap_slot;
  logic [CW-1:0]         rd_row, rd_col;
  logic                  rd_pend_q;
  logic [3:0]            rd_k_q;

  assign ram_we  = (cmd_i.op == OP_WRITE) && (32'(pos_x_i) < MAX_DIM)
                   && (32'(pos_y_i) < MAX_DIM);
  assign waddr   = AW'(pos_y_i) * DIM_A + AW'(pos_x_i);
  assign rd_slot = slot_of(cmd_i.idx, mode_q);
  assign rd_row  = lo_y_q + CW'(rd_slot[3:2]);
  assign rd_col  = lo_x_q + CW'(rd_slot[1:0]);
  assign raddr   = AW'(rd_row) * DIM_A + AW'(rd_col);
  assign cap_slot = slot_of(rd_k_q, mode_q);

  iri_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (pixel_in_i),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= (cmd_i.op == OP_FETCH);
    end
  end

  // window fill, then rows move up as each row pass ends
  logic signed [ACC_W-1:0] row_sh;
  assign row_sh = cubic ? (acc_d >>> 16) : acc_d;

  always_ff @(posedge clk_i) begin
    rd_k_q <= cmd_i.idx;
    if (rd_pend_q) begin
      pw_q[cap_slot[3:2]][cap_slot[1:0]] <= ram_rdata;
    end else if (cmd_i.op == OP_ROW && cmd_i.last) begin
      for (int k = 0; k < 3; k++) pw_q[k] <= pw_q[k+1];
    end
    if (cmd_i.op == OP_ROW && cmd_i.last) begin
      for (int k = 0; k < 3; k++) r_q[k] <= r_q[k+1];
      r_q[3] <= $signed(row_sh[R_W-1:0]);
    end
  end

  // final scaling, clamp and result register
  logic signed [ACC_W-1:0] vfin;
  logic [PIXEL_BITS-1:0]   vsat, result;
  logic                    res_valid_q;
  logic [PIXEL_BITS-1:0]   res_q;

  always_comb begin
    vfin = cubic ? (acc_q >>> 32) : (acc_q >>> 16);
    if (vfin[ACC_W-1])                   vsat = '0;
    else if (|vfin[ACC_W-2:PIXEL_BITS])  vsat = BACKGROUND;
    else                                 vsat = vfin[PIXEL_BITS-1:0];
    if (!inb_q || mode_q == MODE_BACKGROUND) result = BACKGROUND;
    else if (mode_q == MODE_NEAREST)         result = pw_q[0][0];
    else                                     result = vsat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_FINAL) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FINAL) res_q <= result;
  end

  assign res_valid_o   = res_valid_q;
  assign pixel_out_o   = res_q;
  assign sts_o.mode    = mode_q;
  assign sts_o.inb     = inb_q;
  assign sts_o.out_free = !res_valid_q || res_ready_i;

endmodule

// ===== verif/iri_rot_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the rotated-frame pixel engine: watches the request, result
// and settings ports, predicts each lookup and compares. Depends on iri_pkg, iri_if.
module iri_rot_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  iri_req_if                             req_i,
  iri_res_if                             res_i,
  input  logic                           cfg_we_i,
  input  logic [iri_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [iri_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_cnt_o,
  output int                             pending_o
);
  import iri_pkg::*;

  localparam int DIM = MAX_DIM_DEF;

  // shadow frame and settings
  logic [PIXEL_BITS-1:0]   frame_q [DIM*DIM];
  logic [DIM_CFG_W-1:0]    width_q, height_q;
  logic signed [COEF_W-1:0] cos_q, sin_q;
  logic [POS_W-1:0]        cx_q, cy_q;
  interp_e                 mode_q;

  logic [PIXEL_BITS-1:0] pixel_exp_q [$];
  int                    fail_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pixel_exp_q.size();

  function automatic longint pel(longint col, longint row);
    return longint'(frame_q[row * DIM + col]);
  endfunction

  // Hermite spline with neighbour-difference tangents, weights at 24 fraction bits
  function automatic longint hermite(longint q1, longint q2, longint q3, longint q4,
                                     longint f);
    longint f2, f3, w0, w1, w2, w3;
    f2 = f * f;
    f3 = f2 * f;
    w0 = 2 * f3 - 768 * f2 + (longint'(1) << 24);
    w1 = -2 * f3 + 768 * f2;
    w2 = f3 - 512 * f2 + 65536 * f;
    w3 = f3 - 256 * f2;
    return w0 * q2 + w1 * q3 + w2 * (q2 - q1) + w3 * (q4 - q3);
  endfunction

  function automatic logic [PIXEL_BITS-1:0] rotated_pixel(longint px, longint py);
    longint w, h, dx, dy, xq, yq, i, j, fx, fy, v, top, bot;
    longint r [4];
    w  = (width_q > DIM) ? DIM : longint'(width_q);
    h  = (height_q > DIM) ? DIM : longint'(height_q);
    dx = px - longint'(cx_q);
    dy = py - longint'(cy_q);
    xq = ((longint'(cos_q) * dx + longint'(sin_q) * dy) >>> 6) + 256 * longint'(cx_q);
    yq = ((longint'(cos_q) * dy - longint'(sin_q) * dx) >>> 6) + 256 * longint'(cy_q);
    i  = xq >>> 8;
    j  = yq >>> 8;
    fx = xq - 256 * i;
    fy = yq - 256 * j;
    case (mode_q)
      MODE_NEAREST: begin
        if (i < 0 || j < 0 || i >= w || j >= h) return BACKGROUND;
        return PIXEL_BITS'(pel(i, j));
      end
      MODE_BILINEAR: begin
        if (i < 0 || j < 0 || i + 1 >= w || j + 1 >= h) return BACKGROUND;
        top = pel(i, j) * (256 - fx) + pel(i + 1, j) * fx;
        bot = pel(i, j + 1) * (256 - fx) + pel(i + 1, j + 1) * fx;
        v = (top * (256 - fy) + bot * fy) >>> 16;
      end
      MODE_BICUBIC: begin
        if (i < 1 || j < 1 || i + 2 >= w || j + 2 >= h) return BACKGROUND;
        for (int k = 0; k < 4; k++) begin
          r[k] = hermite(pel(i - 1, j - 1 + k), pel(i, j - 1 + k),
                         pel(i + 1, j - 1 + k), pel(i + 2, j - 1 + k), fx) >>> 16;
        end
        v = hermite(r[0], r[1], r[2], r[3], fy) >>> 32;
      end
      default: return BACKGROUND;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PIXEL_BITS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_CFG_W'(512);
      height_q <= DIM_CFG_W'(512);
      cos_q    <= 16'sd16384;
      sin_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      mode_q   <= MODE_NEAREST;
      fail_cnt <= 0;
      pixel_exp_q.delete();
    end else begin
      // settings writes
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_FRAME_WIDTH:  width_q  <= cfg_data_i[DIM_CFG_W-1:0];
          CFG_FRAME_HEIGHT: height_q <= cfg_data_i[DIM_CFG_W-1:0];
          CFG_COS_COEF:     cos_q    <= cfg_data_i;
          CFG_SIN_COEF:     sin_q    <= cfg_data_i;
          CFG_CENTRE_X:     cx_q     <= cfg_data_i[POS_W-1:0];
          CFG_CENTRE_Y:     cy_q     <= cfg_data_i[POS_W-1:0];
          CFG_INTERP_MODE:  mode_q   <= interp_e'(cfg_data_i[1:0]);
          default: ;
        endcase
      end
      // result compare against the oldest expectation
      if (res_i.valid && res_i.ready) begin
        if (pixel_exp_q.size() == 0) begin
          if (fail_cnt < 10) $display("unexpected result pixel_out=%0d", res_i.pixel_out);
          fail_cnt <= fail_cnt + 1;
        end else begin
          if (res_i.pixel_out !== pixel_exp_q[0]) begin
            if (fail_cnt < 10)
              $display("pixel_out mismatch: expected %0d, got %0d",
                       pixel_exp_q[0], res_i.pixel_out);
            fail_cnt <= fail_cnt + 1;
          end
          void'(pixel_exp_q.pop_front());
        end
      end
      // accepted request: store write or lookup
      if (req_i.valid && req_i.ready) begin
        if (req_i.action == 1'b0)
          frame_q[int'(req_i.pos_y) * DIM + int'(req_i.pos_x)] = req_i.pixel_in;
        else
          pixel_exp_q.push_back(rotated_pixel(longint'(req_i.pos_x), longint'(req_i.pos_y)));
      end
    end
  end

endmodule

// ===== verif/image_rotate_interpolate_tb.sv =====
`timescale 1ns / 1ps
// Top of the rotated-frame pixel engine testbench: clock, reset, stimulus and
// verdict. Depends on iri_pkg, iri_if, image_rotate_interpolate, iri_rot_checker.
module image_rotate_interpolate_tb;
  import iri_pkg::*;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;
  localparam int   SETTLE_CYC = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int   fail_cnt, pending;
  bit   quiet = 1'b0;
  int   n_writes = 0;
  int   n_lookups [4] = '{0, 0, 0, 0};
  interp_e cur_mode = MODE_NEAREST;

  iri_req_if req ();
  iri_res_if res ();

  image_rotate_interpolate dut (
    .clk_i, .rst_ni, .req_i(req), .res_o(res),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  iri_rot_checker u_checker (
    .clk_i, .rst_ni, .req_i(req), .res_i(res),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("image_rotate_interpolate_tb: done, errors");
    $finish;
  end

  // result side backpressure in bursts
  initial begin
    int n;
    res.ready = 1'b1;
    forever begin
      n = $urandom_range(1, 12);
      repeat (n) @(negedge clk_i) res.ready <= 1'b1;
      if (!quiet) begin
        n = $urandom_range(1, 6);
        repeat (n) @(negedge clk_i) res.ready <= 1'b0;
      end
    end
  end

  // one request, with an occasional idle burst ahead of it
  task automatic send_req(logic act, int x, int y, int p);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) @(negedge clk_i) req.valid <= 1'b0;
    end
    @(negedge clk_i);
    req.valid    <= 1'b1;
    req.action   <= act;
    req.pos_x    <= POS_W'(x);
    req.pos_y    <= POS_W'(y);
    req.pixel_in <= PIXEL_BITS'(p);
    do @(posedge clk_i); while (!req.ready);
    if (act == ACT_WRITE) n_writes++;
    else n_lookups[cur_mode]++;
  endtask

  task automatic lookup(int x, int y);
    send_req(ACT_LOOKUP, x, y, $urandom_range(0, 255));
  endtask

  // drain, let the engine go idle, then rewrite every setting
  task automatic set_regs(int w, int h, int c, int s, int cx, int cy, interp_e m);
    @(negedge clk_i) req.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_FRAME_WIDTH;  cfg_data_i <= CFG_DATA_W'(w);
    @(negedge clk_i);
    cfg_idx_i <= CFG_FRAME_HEIGHT; cfg_data_i <= CFG_DATA_W'(h);
    @(negedge clk_i);
    cfg_idx_i <= CFG_COS_COEF;     cfg_data_i <= CFG_DATA_W'(c);
    @(negedge clk_i);
    cfg_idx_i <= CFG_SIN_COEF;     cfg_data_i <= CFG_DATA_W'(s);
    @(negedge clk_i);
    cfg_idx_i <= CFG_CENTRE_X;     cfg_data_i <= CFG_DATA_W'(cx);
    @(negedge clk_i);
    cfg_idx_i <= CFG_CENTRE_Y;     cfg_data_i <= CFG_DATA_W'(cy);
    @(negedge clk_i);
    cfg_idx_i <= CFG_INTERP_MODE;  cfg_data_i <= CFG_DATA_W'(m);
    @(negedge clk_i) cfg_we_i <= 1'b0;
    cur_mode = m;
  endtask

  function automatic int clamp_pos(int v);
    return (v < 0) ? 0 : ((v > 511) ? 511 : v);
  endfunction

  // random settings over a small frame, inside the filled 16x16 corner
  task automatic small_phase(int items);
    int w, h, c, s, cx, cy, x, y;
    w  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 16);
    h  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 16);
    c  = $urandom_range(0, 32768) - 16384;
    s  = $urandom_range(0, 32768) - 16384;
    cx = $urandom_range(0, 15);
    cy = $urandom_range(0, 15);
    set_regs(w, h, c, s, cx, cy, interp_e'($urandom_range(0, 3)));
    repeat (items) begin
      case ($urandom_range(0, 19))
        0, 1: send_req(ACT_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 255));
        2:    send_req(ACT_WRITE, $urandom_range(0, 511), $urandom_range(0, 511),
                       $urandom_range(0, 255));
        3:    lookup($urandom_range(0, 511), $urandom_range(0, 511));
        default: begin
          x = clamp_pos(cx + $urandom_range(0, 16) - 8);
          y = clamp_pos(cy + $urandom_range(0, 16) - 8);
          lookup(x, y);
        end
      endcase
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.action = ACT_WRITE;
    req.pos_x = '0;
    req.pos_y = '0;
    req.pixel_in = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // fill the 16x16 corner, frame limited to it before any lookup
    for (int y = 0; y < 16; y++)
      for (int x = 0; x < 16; x++)
        send_req(ACT_WRITE, x, y, (x == 0 && y == 0) ? 0 :
                 ((x == 15 && y == 15) ? 255 : $urandom_range(0, 255)));

    // directed: every mode at frame corners, edges and outside
    for (int m = 0; m < 4; m++) begin
      set_regs(16, 16, 16384, 0, 0, 0, interp_e'(m));
      lookup(0, 0); lookup(15, 15); lookup(14, 14); lookup(1, 1); lookup(511, 511);
    end
    // fractional positions under a 45 degree turn, and negative coefficients
    set_regs(16, 16, 11585, 11585, 8, 8, MODE_BICUBIC);
    lookup(8, 8); lookup(9, 7); lookup(11, 10);
    set_regs(16, 16, 11585, -11585, 8, 8, MODE_BILINEAR);
    lookup(9, 7); lookup(6, 10);
    set_regs(16, 16, -16384, 16384, 15, 0, MODE_NEAREST);
    lookup(14, 0); lookup(15, 1);
    set_regs(16, 16, 0, -16384, 0, 15, MODE_BICUBIC);
    lookup(3, 12);
    // zero-size frame answers background everywhere
    set_regs(0, 16, 16384, 0, 0, 0, MODE_NEAREST);
    lookup(0, 0);
    set_regs(16, 0, 16384, 0, 0, 0, MODE_BILINEAR);
    lookup(3, 3);

    // random phases; each setting change waits for every pending result
    repeat (6) small_phase(55);

    // wide frame: fill the right end of four rows, then oversize and
    // full-width settings that only sample there or in the filled corner
    for (int y = 0; y < 4; y++)
      for (int x = 480; x < 512; x++)
        send_req(ACT_WRITE, x, y, $urandom_range(0, 255));
    for (int m = 0; m < 4; m++) begin
      set_regs(1023, 4, 16384, 0, 511, 1, interp_e'(m));
      lookup(511, 1); lookup(510, 1); lookup(0, 0); lookup(509, 2);
    end
    repeat (4) begin
      set_regs(512, 4, $urandom_range(16000, 16384), $urandom_range(0, 600) - 300,
               $urandom_range(498, 511), $urandom_range(1, 2),
               interp_e'($urandom_range(0, 2)));
      repeat (30) lookup($urandom_range(500, 511), $urandom_range(0, 3));
    end

    // closing stretch without idling on either side
    quiet = 1'b1;
    repeat (2) small_phase(30);

    @(negedge clk_i) req.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    $display("covered %0d frame writes; lookups nearest %0d, bilinear %0d, bicubic %0d,",
             n_writes, n_lookups[0], n_lookups[1], n_lookups[2]);
    $display("background %0d, across zero, small, full and oversize frames", n_lookups[3]);
    if (fail_cnt == 0) begin
      $display("image_rotate_interpolate_tb: done, clean");
    end else begin
      $display("image_rotate_interpolate_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/iri_pkg.sv
rtl/iri_if.sv
rtl/iri_ram.sv
rtl/iri_ctrl.sv
rtl/iri_datapath.sv
rtl/image_rotate_interpolate.sv
verif/iri_rot_checker.sv
verif/image_rotate_interpolate_tb.sv
